// ===== rtl/srd_pkg.sv =====
package srd_pkg;

   // side information that rides with each item down the pipeline
   typedef struct packed {
      logic neg;       // exactly one operand negative
      logic div_zero;  // divisor was zero
   } srd_flags_type;

endpackage

// ===== rtl/signed_restoring_divider_core.sv =====
// an accepted req beat passes through the operand register, one restoring step per bit,
// and the sign and saturation register on the way to its rsp beat
// throughput: one beat per cycle; each stage holds its item while downstream stalls
// reset clears every stage valid bit; data registers are not reset
module signed_restoring_divider_core
   import srd_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   localparam int ReqWidth = ((2 * DATA_WIDTH + 7) / 8) * 8,
   localparam int RspWidth = ((DATA_WIDTH + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqWidth-1:0] req_tdata,   // dividend, divisor
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspWidth-1:0] rsp_tdata    // quotient
);

   localparam logic [DATA_WIDTH-1:0] MaxPos = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   logic [DATA_WIDTH-1:0] dividend;
   logic [DATA_WIDTH-1:0] divisor;
   logic [DATA_WIDTH-1:0] num_mag;
   logic [DATA_WIDTH-1:0] den_mag;

   logic                  in_valid_ff;
   logic [DATA_WIDTH-1:0] in_num_ff;
   logic [DATA_WIDTH-1:0] in_den_ff;
   srd_flags_type         in_flags_ff, in_flags_in;

   logic                  st_valid [0:DATA_WIDTH];
   logic                  st_ready [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] st_rem   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] st_num   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] st_den   [0:DATA_WIDTH];
   srd_flags_type         st_flags [0:DATA_WIDTH];

   logic                  out_valid_ff;
   logic [DATA_WIDTH-1:0] quot_ff, quot_in;
   logic [DATA_WIDTH-1:0] q;

   assign dividend = req_tdata[DATA_WIDTH-1:0];
   assign divisor  = req_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

   always_comb begin
      num_mag = dividend[DATA_WIDTH-1] ? (~dividend + 1'b1) : dividend;
      den_mag = divisor[DATA_WIDTH-1] ? (~divisor + 1'b1) : divisor;
      in_flags_in.neg      = dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
      in_flags_in.div_zero = (divisor == '0);
   end

   assign req_tready = !in_valid_ff || st_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_num_ff   <= num_mag;
         in_den_ff   <= den_mag;
         in_flags_ff <= in_flags_in;
      end
   end

   assign st_valid[0] = in_valid_ff;
   assign st_rem[0]   = '0;
   assign st_num[0]   = in_num_ff;
   assign st_den[0]   = in_den_ff;
   assign st_flags[0] = in_flags_ff;

   for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
      srd_stage #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .in_valid (st_valid[k]),
         .in_ready (st_ready[k]),
         .in_rem   (st_rem[k]),
         .in_num   (st_num[k]),
         .in_den   (st_den[k]),
         .in_flags (st_flags[k]),
         .out_valid(st_valid[k+1]),
         .out_ready(st_ready[k+1]),
         .out_rem  (st_rem[k+1]),
         .out_num  (st_num[k+1]),
         .out_den  (st_den[k+1]),
         .out_flags(st_flags[k+1])
      );
   end

   // quotient magnitude has been shifted fully into the numerator slot
   assign q = st_num[DATA_WIDTH];

   always_comb begin
      priority if (st_flags[DATA_WIDTH].div_zero) begin
         quot_in = MaxPos;
      end else if (st_flags[DATA_WIDTH].neg) begin
         quot_in = (q[DATA_WIDTH-1] && (q[DATA_WIDTH-2:0] != '0)) ? MaxPos : (~q + 1'b1);
      end else begin
         quot_in = q[DATA_WIDTH-1] ? MaxPos : q;
      end
   end

   assign st_ready[DATA_WIDTH] = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (st_ready[DATA_WIDTH]) begin
         out_valid_ff <= st_valid[DATA_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (st_ready[DATA_WIDTH] && st_valid[DATA_WIDTH]) begin
         quot_ff <= quot_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RspWidth'(quot_ff);

endmodule

// ===== rtl/srd_stage.sv =====
module srd_stage
   import srd_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [DATA_WIDTH-1:0] in_rem,
   input  logic [DATA_WIDTH-1:0] in_num,
   input  logic [DATA_WIDTH-1:0] in_den,
   input  srd_flags_type         in_flags,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [DATA_WIDTH-1:0] out_rem,
   output logic [DATA_WIDTH-1:0] out_num,
   output logic [DATA_WIDTH-1:0] out_den,
   output srd_flags_type         out_flags
);

   logic                  valid_ff;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] num_ff, num_in;
   logic [DATA_WIDTH-1:0] den_ff;
   srd_flags_type         flags_ff;
   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH:0]   diff;
   logic                  fits;

   assign in_ready = !valid_ff || out_ready;

   // shift in the next dividend bit, keep the difference if the divisor fits
   always_comb begin
      shifted = {in_rem, in_num[DATA_WIDTH-1]};
      diff    = shifted - {1'b0, in_den};
      fits    = !diff[DATA_WIDTH];
      rem_in  = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      num_in  = {in_num[DATA_WIDTH-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rem_ff   <= rem_in;
         num_ff   <= num_in;
         den_ff   <= in_den;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_flags = flags_ff;

endmodule

// ===== verif/tb_signed_restoring_divider_core.sv =====
module tb_signed_restoring_divider_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW = 32;
   localparam logic signed [DW-1:0] QMAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] QMIN = {1'b1, {(DW-1){1'b0}}};
   localparam int PIPE_DEPTH = DW + 2;

   typedef struct packed {
      logic signed [DW-1:0] divisor;
      logic signed [DW-1:0] dividend;
   } div_operands_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [2*DW-1:0] req_tdata = '0;   // dividend, divisor
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [DW-1:0] rsp_tdata;          // quotient

   div_operands_type div_pending[$];
   logic signed [DW-1:0] quotient_expected[$];

   int total_items = 0;
   int accepted_count = 0;
   int checked_count = 0;
   int mismatch_count = 0;
   int zero_div_count = 0;
   int saturate_count = 0;
   int negative_count = 0;

   logic req_fire = 1'b0;
   int burst_left = 0;
   int gap_left = 0;
   int ready_mode = 0;
   int ready_left = 0;
   int ready_phase = 0;

   signed_restoring_divider_core #(.DATA_WIDTH(DW)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // restoring shift-and-subtract on the magnitudes, sign applied afterwards
   function automatic logic signed [DW-1:0] divide_truncated(logic signed [DW-1:0] num,
                                                            logic signed [DW-1:0] den);
      logic neg;
      logic [DW-1:0] n_mag;
      logic [DW-1:0] d_mag;
      logic [DW-1:0] q;
      logic [DW:0] r;
      int i;
      neg = num[DW-1] ^ den[DW-1];
      n_mag = num[DW-1] ? (~num + 1'b1) : num;
      d_mag = den[DW-1] ? (~den + 1'b1) : den;
      q = '0;
      r = '0;
      if (d_mag == '0) return QMAX;
      for (i = DW - 1; i >= 0; i--) begin
         r = {r[DW-1:0], n_mag[i]};
         if (r >= {1'b0, d_mag}) begin
            r = r - {1'b0, d_mag};
            q[i] = 1'b1;
         end
      end
      if (neg) begin
         if (q > QMIN) return QMAX;
         return ~q + 1'b1;
      end
      if (q > QMAX) return QMAX;
      return q;
   endfunction

   function automatic logic signed [DW-1:0] small_signed(int span);
      return $signed($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic logic signed [DW-1:0] edge_value();
      case ($urandom_range(0, 8))
         0: return QMIN;
         1: return QMAX;
         2: return QMIN + 1;
         3: return QMAX - 1;
         4: return -1;
         5: return 1;
         6: return 0;
         7: return 2;
         default: return -2;
      endcase
   endfunction

   // driver: bursts of beats separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (div_pending.size() > 0) begin
            req_tdata <= div_pending.pop_front();
            req_tvalid <= 1'b1;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 48);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver stall pattern switches between randomly chosen modes
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_left = $urandom_range(50, 300);
      end
      ready_left--;
      ready_phase = (ready_phase + 1) % 8;
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 7) == 0);
         default: rsp_tready <= (ready_phase < 3);
      endcase
   end

   // monitor: predict on each accepted request beat, check each response beat
   always @(posedge clock) begin
      req_fire <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         quotient_expected.push_back(divide_truncated(req_tdata[DW-1:0], req_tdata[2*DW-1:DW]));
         accepted_count++;
         if (req_tdata[2*DW-1:DW] == '0) zero_div_count++;
         else if (req_tdata[DW-1:0] == QMIN && $signed(req_tdata[2*DW-1:DW]) == -1)
            saturate_count++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (quotient_expected.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected rsp beat: quotient %0d", $signed(rsp_tdata));
         end else begin
            if (rsp_tdata !== quotient_expected[0]) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("quotient mismatch on beat %0d: expected %0d, got %0d",
                           checked_count, quotient_expected[0], $signed(rsp_tdata));
            end
            if (quotient_expected[0][DW-1]) negative_count++;
            void'(quotient_expected.pop_front());
            checked_count++;
         end
      end
   end

   initial begin
      div_operands_type item;
      logic signed [DW-1:0] den;
      int k;
      // directed: extremes, zero divisor, overflow, exact most negative result, sign mix
      div_pending.push_back('{divisor: 0, dividend: 0});
      div_pending.push_back('{divisor: 0, dividend: 5});
      div_pending.push_back('{divisor: 0, dividend: QMIN});
      div_pending.push_back('{divisor: 0, dividend: QMAX});
      div_pending.push_back('{divisor: -1, dividend: QMIN});
      div_pending.push_back('{divisor: 1, dividend: QMIN});
      div_pending.push_back('{divisor: 2, dividend: QMIN});
      div_pending.push_back('{divisor: 1, dividend: QMAX});
      div_pending.push_back('{divisor: -1, dividend: QMAX});
      div_pending.push_back('{divisor: QMIN, dividend: QMIN});
      div_pending.push_back('{divisor: QMAX, dividend: QMAX});
      div_pending.push_back('{divisor: QMAX, dividend: QMIN});
      div_pending.push_back('{divisor: QMIN, dividend: QMAX});
      div_pending.push_back('{divisor: QMIN, dividend: 1});
      div_pending.push_back('{divisor: 2, dividend: 7});
      div_pending.push_back('{divisor: -2, dividend: 7});
      div_pending.push_back('{divisor: 2, dividend: -7});
      div_pending.push_back('{divisor: -2, dividend: -7});
      div_pending.push_back('{divisor: -1, dividend: -1});
      div_pending.push_back('{divisor: -5, dividend: 0});
      div_pending.push_back('{divisor: 7, dividend: 100});
      div_pending.push_back('{divisor: 32'h5555_5555, dividend: 32'hAAAA_AAAA});
      for (int n = 0; n < 1250; n++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               item.dividend = $urandom;
               item.divisor = $urandom;
            end
            4, 5: begin
               item.dividend = $urandom;
               item.divisor = small_signed(300);
            end
            6: begin
               item.dividend = small_signed(1000);
               item.divisor = small_signed(40);
            end
            7: begin
               item.dividend = ($urandom_range(0, 1) == 0) ? edge_value() : $urandom;
               item.divisor = ($urandom_range(0, 1) == 0) ? edge_value() : $urandom;
            end
            8: begin
               den = 32'sd1 <<< $urandom_range(0, DW - 1);
               item.divisor = ($urandom_range(0, 1) == 0) ? den : -den;
               item.dividend = $urandom;
            end
            default: begin
               // exact multiples and neighbors probe the remainder boundary
               den = small_signed(5000);
               k = $signed($urandom_range(0, 200000)) - 100000;
               item.divisor = den;
               item.dividend = den * k + small_signed(1);
            end
         endcase
         div_pending.push_back(item);
      end
      total_items = div_pending.size();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accepted_count < total_items) @(negedge clock);
      while (quotient_expected.size() != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 8) @(negedge clock);
      mismatch_count += quotient_expected.size();

      $display("checked %0d quotients: %0d by zero divisor, %0d overflow, %0d negative",
               checked_count, zero_div_count, saturate_count, negative_count);
      $display("%0d mismatches", mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS signed_restoring_divider_core");
      end else begin
         $display("FAIL signed_restoring_divider_core");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("timeout after %0d of %0d beats accepted", accepted_count, total_items);
      $display("FAIL signed_restoring_divider_core");
      $finish;
   end

endmodule
